// ----- sv/whv_pkg.sv -----
// Package for the weighted rectangle hypervolume unit.
// Holds the transfer payload types, the operation codes and the sequencer states.
// It depends on nothing else.
`timescale 1ns / 1ps
package whv_pkg;

    localparam int CoordBits  = 20;
    localparam int WeightBits = 16;
    localparam int VolBits    = 63;

    typedef enum logic [1:0] {
        FUNC_POINT   = 2'd0,
        FUNC_RECT    = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef struct packed {
        func_t                        func;
        logic signed [CoordBits-1:0]  coord_x;
        logic signed [CoordBits-1:0]  coord_y;
        logic signed [CoordBits-1:0]  upper_x;
        logic signed [CoordBits-1:0]  upper_y;
        logic        [WeightBits-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [VolBits-1:0] volume;
        logic               load_overflow;
        logic               sum_saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
    } point_t;

    typedef struct packed {
        logic signed [CoordBits-1:0]  lx;
        logic signed [CoordBits-1:0]  ly;
        logic signed [CoordBits-1:0]  ux;
        logic signed [CoordBits-1:0]  uy;
        logic        [WeightBits-1:0] wt;
    } rect_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_CMP_START,
        ST_SM_RD,
        ST_SM_WR,
        ST_PT_RD,
        ST_PT_LAT,
        ST_RC_RD,
        ST_RC_CALC,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

// ----- sv/whv_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for every store of the hypervolume unit.
`timescale 1ns / 1ps
module whv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/weighted_rect_hypervolume_2d_unit.sv -----
// Weighted 2-D hypervolume unit: loads points and weighted rectangles, computes on request.
// Depends on whv_pkg and on the whv_ram memory module.
`timescale 1ns / 1ps
// A user issues point loads (func 0), rectangle loads (func 1) and a compute
// (func 2) as input transfers; only the compute yields one result transfer, holding
// the weighted dominated area, the load overflow flag and the saturation flag, after
// which both stores are empty again. Points live in a RAM kept sorted by y descending
// and then x ascending; an insertion walks down from the last entry, moving each
// entry that sorts after the new point up by one place. A rectangle load is written
// to its RAM as it is accepted. No transfer is taken while an insertion or a
// compute runs. A compute first builds the running minimum of x in a second RAM,
// then sweeps every point strip against every rectangle through one shared multiply
// path; for each pair it reads the rectangle, forms the clipped width and height,
// multiplies them, multiplies by the weight and accumulates, and it hands over the
// result once the result side is free. The stores need no clearing pass: the fill
// counts alone mark which entries hold data. A finished result waits in an output
// register, and loads are taken while it waits.
module weighted_rect_hypervolume_2d_unit
    import whv_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_RECTS  = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int RCW = $clog2(MAX_RECTS + 1);
    localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int RAW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int DW  = CoordBits + 2;
    localparam int AreaBits = 2 * CoordBits;
    localparam int TermBits = AreaBits + WeightBits;
    localparam logic [VolBits:0] VolMax = {1'b0, {VolBits{1'b1}}};
    localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};

    state_t state_reg, state_next;
    logic [PCW-1:0] pcount_reg, pcount_next;
    logic [RCW-1:0] rcount_reg, rcount_next;
    logic           ovf_reg, ovf_next;
    point_t         new_pt_reg, new_pt_next;
    logic [PCW-1:0] sp_reg, sp_next;
    logic [PCW-1:0] k_reg, k_next;
    logic [RCW-1:0] r_reg, r_next;
    logic signed [CoordBits-1:0] min_reg, min_next;
    logic signed [CoordBits-1:0] cury_reg, cury_next;
    logic signed [CoordBits-1:0] cursm_reg, cursm_next;
    logic signed [CoordBits-1:0] prevy_reg, prevy_next;
    logic [CoordBits-1:0]  w_reg, w_next;
    logic [CoordBits-1:0]  h_reg, h_next;
    logic [WeightBits-1:0] wt_reg, wt_next;
    logic                  live_reg, live_next;
    logic [AreaBits-1:0]   area_reg, area_next;
    logic [TermBits-1:0]   term_reg, term_next;
    logic [VolBits-1:0]    acc_reg, acc_next;
    logic                  sat_reg, sat_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    // Memory ports.
    logic           pt_we;
    logic [PAW-1:0] pt_waddr, pt_raddr;
    point_t         pt_wdata, pt_rdata;
    logic           sm_we;
    logic [PAW-1:0] sm_waddr, sm_raddr;
    logic signed [CoordBits-1:0] sm_wdata, sm_rdata;
    logic           rc_we;
    logic [RAW-1:0] rc_waddr, rc_raddr;
    rect_t          rc_wdata, rc_rdata;

    // Strip arithmetic; the width and height differences are signed values two bits wider than a coordinate.
    logic signed [CoordBits-1:0] xl, yl, yh, xmin;
    logic signed [DW-1:0]        wd, hd;
    logic [VolBits:0]            sum;

    whv_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_pt_ram (
        .aclk(aclk), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
        .rd_addr(pt_raddr), .rd_data(pt_rdata)
    );

    whv_ram #(.WIDTH(CoordBits), .DEPTH(MAX_POINTS)) u_sm_ram (
        .aclk(aclk), .wr_en(sm_we), .wr_addr(sm_waddr), .wr_data(sm_wdata),
        .rd_addr(sm_raddr), .rd_data(sm_rdata)
    );

    whv_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_RECTS)) u_rc_ram (
        .aclk(aclk), .wr_en(rc_we), .wr_addr(rc_waddr), .wr_data(rc_wdata),
        .rd_addr(rc_raddr), .rd_data(rc_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The strip of point k spans from its own y up to the y of point k-1.
    always_comb begin
        xl = (cursm_reg > rc_rdata.lx) ? cursm_reg : rc_rdata.lx;
        yl = (cury_reg > rc_rdata.ly) ? cury_reg : rc_rdata.ly;
        yh = rc_rdata.uy;
        if ((k_reg != '0) && (prevy_reg < rc_rdata.uy)) begin
            yh = prevy_reg;
        end
        wd = DW'(rc_rdata.ux) - DW'(xl);
        hd = DW'(yh) - DW'(yl);
        xmin = (pt_rdata.x < min_reg) ? pt_rdata.x : min_reg;
        sum = {1'b0, acc_reg} + (VolBits + 1)'(term_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pcount_reg  <= '0;
            rcount_reg  <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pcount_reg  <= pcount_next;
            rcount_reg  <= rcount_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        new_pt_reg <= new_pt_next;
        sp_reg     <= sp_next;
        k_reg      <= k_next;
        r_reg      <= r_next;
        min_reg    <= min_next;
        cury_reg   <= cury_next;
        cursm_reg  <= cursm_next;
        prevy_reg  <= prevy_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        wt_reg     <= wt_next;
        live_reg   <= live_next;
        area_reg   <= area_next;
        term_reg   <= term_next;
        acc_reg    <= acc_next;
        sat_reg    <= sat_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        pcount_next  = pcount_reg;
        rcount_next  = rcount_reg;
        ovf_next     = ovf_reg;
        new_pt_next  = new_pt_reg;
        sp_next      = sp_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        min_next     = min_reg;
        cury_next    = cury_reg;
        cursm_next   = cursm_reg;
        prevy_next   = prevy_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        wt_next      = wt_reg;
        live_next    = live_reg;
        area_next    = area_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        pt_we    = 1'b0;
        pt_waddr = sp_reg[PAW-1:0];
        pt_wdata = new_pt_reg;
        pt_raddr = k_reg[PAW-1:0];
        sm_we    = 1'b0;
        sm_waddr = k_reg[PAW-1:0];
        sm_wdata = xmin;
        sm_raddr = k_reg[PAW-1:0];
        rc_we    = 1'b0;
        rc_waddr = rcount_reg[RAW-1:0];
        rc_wdata = '{lx: s_data.coord_x, ly: s_data.coord_y, ux: s_data.upper_x,
                     uy: s_data.upper_y, wt: s_data.weight};
        rc_raddr = r_reg[RAW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.func)
                        FUNC_POINT: begin
                            if (pcount_reg == PCW'(MAX_POINTS)) begin
                                ovf_next = 1'b1;
                            end else begin
                                new_pt_next = '{x: s_data.coord_x, y: s_data.coord_y};
                                sp_next     = pcount_reg;
                                state_next  = ST_INS_RD;
                            end
                        end
                        FUNC_RECT: begin
                            if (rcount_reg == RCW'(MAX_RECTS)) begin
                                ovf_next = 1'b1;
                            end else begin
                                rc_we       = 1'b1;
                                rcount_next = rcount_reg + 1'b1;
                            end
                        end
                        FUNC_COMPUTE: begin
                            acc_next   = '0;
                            sat_next   = 1'b0;
                            state_next = ST_CMP_START;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Sorted insertion: read the entry below the gap, then either move it up
            // into the gap or drop the new point into the gap.
            ST_INS_RD: begin
                pt_raddr = PAW'(sp_reg - 1'b1);
                if (sp_reg == '0) begin
                    pt_we       = 1'b1;
                    pcount_next = pcount_reg + 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                pt_we = 1'b1;
                if ((new_pt_reg.y > pt_rdata.y) ||
                    ((new_pt_reg.y == pt_rdata.y) && (new_pt_reg.x < pt_rdata.x))) begin
                    pt_wdata   = pt_rdata;
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_INS_RD;
                end else begin
                    pcount_next = pcount_reg + 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_CMP_START: begin
                if ((pcount_reg == '0) || (rcount_reg == '0)) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = pcount_reg;
                    min_next   = CoordMax;
                    state_next = ST_SM_RD;
                end
            end
            // Backward pass: the least x from each point to the end of the list.
            ST_SM_RD: begin
                pt_raddr   = PAW'(k_reg - 1'b1);
                state_next = ST_SM_WR;
            end
            ST_SM_WR: begin
                sm_we    = 1'b1;
                sm_waddr = PAW'(k_reg - 1'b1);
                min_next = xmin;
                k_next   = k_reg - 1'b1;
                if (k_reg == PCW'(1)) begin
                    state_next = ST_PT_RD;
                end else begin
                    state_next = ST_SM_RD;
                end
            end
            ST_PT_RD: begin
                state_next = ST_PT_LAT;
            end
            ST_PT_LAT: begin
                cury_next  = pt_rdata.y;
                cursm_next = sm_rdata;
                r_next     = '0;
                state_next = ST_RC_RD;
            end
            ST_RC_RD: begin
                state_next = ST_RC_CALC;
            end
            ST_RC_CALC: begin
                w_next     = wd[CoordBits-1:0];
                h_next     = hd[CoordBits-1:0];
                wt_next    = rc_rdata.wt;
                live_next  = (wd > 0) && (hd > 0) && (rc_rdata.wt != '0);
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                area_next  = AreaBits'(w_reg) * AreaBits'(h_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                term_next  = TermBits'(area_reg) * TermBits'(wt_reg);
                state_next = ST_ACC;
            end
            // Saturating accumulate; once saturated the sum stays at its maximum.
            ST_ACC: begin
                if (live_reg) begin
                    if (sum > VolMax) begin
                        acc_next = VolMax[VolBits-1:0];
                        sat_next = 1'b1;
                    end else begin
                        acc_next = sum[VolBits-1:0];
                    end
                end
                if (r_reg + 1'b1 == rcount_reg) begin
                    prevy_next = cury_reg;
                    k_next     = k_reg + 1'b1;
                    if (k_reg + 1'b1 == pcount_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PT_RD;
                    end
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RC_RD;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = '{volume: acc_reg, load_overflow: ovf_reg,
                                     sum_saturated: sat_reg};
                    m_valid_next = 1'b1;
                    pcount_next  = '0;
                    rcount_next  = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the weighted rectangle hypervolume unit.
// It depends on whv_pkg and on weighted_rect_hypervolume_2d_unit and its memories.
`timescale 1ns / 1ps
module testbench
    import whv_pkg::*;
();

    localparam int          MaxPoints     = 256;
    localparam int          MaxRects      = 64;
    localparam logic [1:0]  FuncUnused    = 2'd3;
    localparam longint unsigned VolMax    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          CoordMin      = -(1 << (CoordBits - 1));
    localparam int          CoordMax      = (1 << (CoordBits - 1)) - 1;
    // The limit covers the longest compute the unit can run, with both stores full.
    localparam int          WatchdogLimit = 400000;
    // A point load shifts up to 255 stored entries.
    localparam int          DrainCycles   = 600;
    localparam int          IdlePercent   = 22;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    weighted_rect_hypervolume_2d_unit #(
        .MAX_POINTS(MaxPoints),
        .MAX_RECTS (MaxRects)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the point and rectangle stores. Points are kept in the
    // same order as the unit keeps them: y descending, then x ascending.
    longint    shadow_px [MaxPoints];
    longint    shadow_py [MaxPoints];
    rect_t     shadow_rects [MaxRects];
    int        shadow_npts   = 0;
    int        shadow_nrects = 0;
    bit        shadow_ovf    = 1'b0;

    out_item_t expected_volumes [$];
    bit        idle_enable   = 1'b1;
    int        fail_count    = 0;
    int        mismatch_count = 0;
    int        items_sent    = 0;
    int        results_seen  = 0;
    int        computes_sent = 0;
    int        quiet_cycles  = 0;

    // Computes the expected result of a compute transfer from the shadow stores.
    function automatic out_item_t weighted_volume();
        longint          suffix_x [MaxPoints];
        longint          xl, yl, yh, w, h;
        longint unsigned area, term, acc;
        bit              sat;
        out_item_t       res;
        acc = 0;
        sat = 1'b0;
        if (shadow_npts > 0 && shadow_nrects > 0) begin
            suffix_x[shadow_npts-1] = shadow_px[shadow_npts-1];
            for (int k = shadow_npts - 1; k > 0; k--) begin
                suffix_x[k-1] = (shadow_px[k-1] < suffix_x[k]) ? shadow_px[k-1] : suffix_x[k];
            end
            for (int k = 0; k < shadow_npts && !sat; k++) begin
                for (int r = 0; r < shadow_nrects && !sat; r++) begin
                    xl = (suffix_x[k] > shadow_rects[r].lx) ? suffix_x[k] : shadow_rects[r].lx;
                    yl = (shadow_py[k] > shadow_rects[r].ly) ? shadow_py[k] : shadow_rects[r].ly;
                    yh = shadow_rects[r].uy;
                    // Each strip is capped by the y of the point above it.
                    if (k > 0 && shadow_py[k-1] < yh) yh = shadow_py[k-1];
                    w = longint'(shadow_rects[r].ux) - xl;
                    h = yh - yl;
                    if (w > 0 && h > 0 && shadow_rects[r].wt != 0) begin
                        area = longint'(w) * longint'(h);
                        if (area > VolMax / shadow_rects[r].wt) begin
                            sat = 1'b1;
                        end else begin
                            term = area * shadow_rects[r].wt;
                            if (term > VolMax - acc) sat = 1'b1;
                            else acc += term;
                        end
                    end
                end
            end
        end
        res.volume        = sat ? VolMax[VolBits-1:0] : acc[VolBits-1:0];
        res.load_overflow = shadow_ovf;
        res.sum_saturated = sat;
        return res;
    endfunction

    // Updates the shadow stores for one accepted input transfer.
    task automatic track_transfer(input in_item_t it);
        int pos;
        pos = 0;
        case (it.func)
            FUNC_POINT: begin
                if (shadow_npts >= MaxPoints) begin
                    shadow_ovf = 1'b1;
                end else begin
                    while (pos < shadow_npts && !(it.coord_y > shadow_py[pos] ||
                           (it.coord_y == shadow_py[pos] && it.coord_x < shadow_px[pos])))
                        pos++;
                    for (int i = shadow_npts; i > pos; i--) begin
                        shadow_px[i] = shadow_px[i-1];
                        shadow_py[i] = shadow_py[i-1];
                    end
                    shadow_px[pos] = it.coord_x;
                    shadow_py[pos] = it.coord_y;
                    shadow_npts++;
                end
            end
            FUNC_RECT: begin
                if (shadow_nrects >= MaxRects) begin
                    shadow_ovf = 1'b1;
                end else begin
                    shadow_rects[shadow_nrects] = '{it.coord_x, it.coord_y, it.upper_x,
                                                    it.upper_y, it.weight};
                    shadow_nrects++;
                end
            end
            FUNC_COMPUTE: begin
                expected_volumes.push_back(weighted_volume());
                computes_sent++;
                shadow_npts   = 0;
                shadow_nrects = 0;
                shadow_ovf    = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Presents one item, holding it until the transfer completes. Idle cycles
    // are inserted before the item, never between raising valid and acceptance.
    task automatic send_item(input in_item_t it);
        while (idle_enable && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        track_transfer(it);
    endtask

    function automatic in_item_t make_item(input logic [1:0] f, input int cx, input int cy,
                                           input int ux, input int uy, input int wt);
        in_item_t it;
        it.func    = func_t'(f);
        it.coord_x = cx[CoordBits-1:0];
        it.coord_y = cy[CoordBits-1:0];
        it.upper_x = ux[CoordBits-1:0];
        it.upper_y = uy[CoordBits-1:0];
        it.weight  = wt[WeightBits-1:0];
        return it;
    endfunction

    function automatic int rand_coord(input bit wide, input int center);
        if (wide) return $signed($urandom_range(CoordMax - CoordMin) + CoordMin);
        return center + $signed($urandom_range(128)) - 64;
    endfunction

    task automatic send_point(input int x, input int y);
        send_item(make_item(FUNC_POINT, x, y, 0, 0, 0));
    endtask

    task automatic send_rect(input int lx, input int ly, input int ux, input int uy,
                             input int wt);
        send_item(make_item(FUNC_RECT, lx, ly, ux, uy, wt));
    endtask

    task automatic send_compute();
        send_item(make_item(FUNC_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    // Extremes of the fields, the unused code, degenerate and zero-weight
    // rectangles, dominated and repeated points, and empty stores.
    task automatic test_directed();
        send_compute();
        send_point(0, 0);
        send_compute();
        send_rect(0, 0, 10, 10, 1);
        send_compute();
        send_item(make_item(FuncUnused, 5, 5, 9, 9, 7));
        send_point(CoordMin, CoordMin);
        send_point(CoordMin, CoordMin);
        send_point(100, 200);
        send_rect(CoordMin, CoordMin, CoordMax, CoordMax, 16'hFFFF);
        send_rect(CoordMax, CoordMax, CoordMin, CoordMin, 16'hFFFF);
        send_rect(-50, -50, 50, 50, 0);
        send_compute();
        send_point(10, 30);
        send_point(20, 10);
        send_point(30, 40);
        send_point(-5, 5);
        send_rect(0, 0, 40, 40, 3);
        send_rect(15, 5, 60, 25, 16'h8000);
        send_rect(7, 7, 7, 20, 9);
        send_compute();
        send_rect(15, 5, 60, 25, 16'h8000);
        send_rect(0, 0, 40, 40, 3);
        send_point(20, 10);
        send_point(10, 30);
        send_compute();
    endtask

    // Fills both stores past their depth, each fill followed by a compute.
    task automatic test_overflow();
        for (int i = 0; i <= MaxPoints; i++)
            send_point(rand_coord(i[0], 0), rand_coord(i[1], 0));
        send_compute();
        for (int i = 0; i <= MaxRects; i++)
            send_rect(rand_coord(1'b0, -200), rand_coord(1'b0, -200), rand_coord(1'b0, 200),
                      rand_coord(1'b0, 200), $urandom);
        send_point(0, 0);
        send_compute();
    endtask

    // Random well-formed load sequences ended by a compute, with some noise.
    task automatic test_random(input int n_items);
        int   budget, npts, nrects, cx, cy;
        bit   wide;
        budget = items_sent + n_items;
        while (items_sent < budget) begin
            // A stretch in the middle runs with no idling on either side.
            idle_enable = !(items_sent > budget - n_items / 2 - 150 &&
                            items_sent < budget - n_items / 2 + 150);
            npts   = $urandom_range(12);
            nrects = $urandom_range(6);
            wide   = ($urandom_range(2) == 0);
            cx     = rand_coord(1'b1, 0) / 2;
            cy     = rand_coord(1'b1, 0) / 2;
            for (int i = 0; i < npts + nrects; i++) begin
                if ($urandom_range(29) == 0)
                    send_item(make_item(FuncUnused, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
                if (($urandom_range(npts + nrects) < npts && npts > 0) || nrects == 0) begin
                    send_point(rand_coord(wide, cx), rand_coord(wide, cy));
                    npts--;
                end else begin
                    if ($urandom_range(9) == 0)
                        send_rect(rand_coord(wide, cx), rand_coord(wide, cy),
                                  rand_coord(wide, cx), rand_coord(wide, cy), $urandom);
                    else
                        send_rect(rand_coord(wide, cx - 60), rand_coord(wide, cy - 60),
                                  rand_coord(wide, cx + 60), rand_coord(wide, cy + 60),
                                  ($urandom_range(1) == 0) ? $urandom : $urandom_range(15));
                    nrects--;
                end
            end
            send_compute();
        end
        idle_enable = 1'b1;
    endtask

    // Result side: random back-pressure and comparison against the oldest
    // expected result.
    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_volumes.size() == 0) begin
                    fail_count++;
                    $display("ERROR: result transfer with nothing expected: volume=%0d",
                             m_data.volume);
                end else begin
                    exp_res = expected_volumes.pop_front();
                    if (m_data.volume !== exp_res.volume ||
                        m_data.load_overflow !== exp_res.load_overflow ||
                        m_data.sum_saturated !== exp_res.sum_saturated) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"MISMATCH: volume exp %0d got %0d, ",
                                      "overflow exp %0b got %0b, saturated exp %0b got %0b"},
                                     exp_res.volume, m_data.volume, exp_res.load_overflow,
                                     m_data.load_overflow, exp_res.sum_saturated,
                                     m_data.sum_saturated);
                    end
                end
            end
            m_ready <= !(idle_enable && $urandom_range(99) < IdlePercent);
        end
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_random(1300);
        s_valid <= 1'b0;
        while (expected_volumes.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        $display("Run covered %0d input transfers, %0d computes and %0d result transfers.",
                 items_sent, computes_sent, results_seen);
        $display("Directed extremes, store overflow and random load sequences were checked.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d mismatches.", fail_count, mismatch_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
